// File: sv/pulse_width_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// Pulse-width frame decoder assertion macros
// Clocked assertion shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_FRAME_DECODER_MACROS_SVH
`define PULSE_WIDTH_FRAME_DECODER_MACROS_SVH

// Check a property outside reset
`define PWFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included
`define PWFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/pwfd_pkg.sv
// ----------------------------------------------------------------------------
// pwfd_pkg
// Shared types and constants of the pulse-width frame decoder.
// ----------------------------------------------------------------------------
package pwfd_pkg;

  // Field widths
  localparam int TIME_W     = 10;
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 6;
  localparam int LENGTH_W   = 7;
  localparam int EXPECT_W   = 9;
  localparam int BITPOS_W   = 3;
  localparam int CFG_IDX_W  = 3;

  // Default frame capacity in bytes
  localparam int FRAME_CAPACITY_DEFAULT = 64;

  // Queue between front and back, and result queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOURTH_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE   = 3'd5;

  // Register reset values
  localparam logic [TIME_W-1:0] FIRST_START_RST  = 10'd80;
  localparam logic [TIME_W-1:0] SECOND_START_RST = 10'd80;
  localparam logic [TIME_W-1:0] THIRD_START_RST  = 10'd20;
  localparam logic [TIME_W-1:0] FOURTH_START_RST = 10'd20;
  localparam logic [TIME_W-1:0] GAP_TIMEOUT_RST  = 10'd200;
  localparam logic [TIME_W-1:0] LONG_PULSE_RST   = 10'd20;

  // Length byte offset
  localparam logic [EXPECT_W-1:0] LENGTH_OFFSET = 9'd2;

  // Receive phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START1 = 3'd1,
    PH_START2 = 3'd2,
    PH_START3 = 3'd3,
    PH_START4 = 3'd4,
    PH_DUMMY  = 3'd5,
    PH_DATA   = 3'd6
  } phase_t;

  // One classified edge
  typedef struct packed {
    logic level;
    logic over_first;
    logic over_second;
    logic over_third;
    logic over_fourth;
    logic over_gap;
    logic long_pulse;
  } edge_class_t;

  // One result item
  typedef struct packed {
    logic                byte_valid;
    logic [BYTE_W-1:0]   data_byte;
    logic [INDEX_W-1:0]  byte_index;
    logic                frame_done;
    logic [LENGTH_W-1:0] frame_length;
    logic                timed_out;
  } result_t;

endpackage

// File: sv/pwfd_front.sv
// ----------------------------------------------------------------------------
// pwfd_front
// Holds the width thresholds, classifies each edge against them and queues
// the classified edges for the decoder.
// ----------------------------------------------------------------------------
module pwfd_front
  import pwfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic                 line_level,
  input  logic [TIME_W-1:0]    interval,
  output logic                 item_valid,
  output edge_class_t          item,
  input  logic                 item_pop
);

  logic [TIME_W-1:0] first_start_min;
  logic [TIME_W-1:0] second_start_min;
  logic [TIME_W-1:0] third_start_min;
  logic [TIME_W-1:0] fourth_start_min;
  logic [TIME_W-1:0] gap_timeout;
  logic [TIME_W-1:0] long_pulse_min;

  edge_class_t             in_class;
  edge_class_t             qmem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;
  logic                    do_push;

  assign cfg_ready = 1'b1;

  // Write threshold registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      first_start_min  <= FIRST_START_RST;
      second_start_min <= SECOND_START_RST;
      third_start_min  <= THIRD_START_RST;
      fourth_start_min <= FOURTH_START_RST;
      gap_timeout      <= GAP_TIMEOUT_RST;
      long_pulse_min   <= LONG_PULSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIRST_START:  first_start_min  <= cfg_data;
        REG_SECOND_START: second_start_min <= cfg_data;
        REG_THIRD_START:  third_start_min  <= cfg_data;
        REG_FOURTH_START: fourth_start_min <= cfg_data;
        REG_GAP_TIMEOUT:  gap_timeout      <= cfg_data;
        REG_LONG_PULSE:   long_pulse_min   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the incoming edge
  always_comb begin
    in_class.level       = line_level;
    in_class.over_first  = interval > first_start_min;
    in_class.over_second = interval > second_start_min;
    in_class.over_third  = interval > third_start_min;
    in_class.over_fourth = interval > fourth_start_min;
    in_class.over_gap    = interval > gap_timeout;
    in_class.long_pulse  = interval > long_pulse_min;
  end

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push    = push && !full;
  assign item_valid = (count != '0);
  assign item       = qmem[rd_ptr];

  // Store classified edges
  always_ff @(posedge clk) begin
    if (do_push) begin
      qmem[wr_ptr] <= in_class;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (item_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !item_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!do_push && item_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: sv/pwfd_back.sv
// ----------------------------------------------------------------------------
// pwfd_back
// Walks the start preamble, samples data bits, packs bytes and tracks the
// frame length; makes at most one result per classified edge.
// ----------------------------------------------------------------------------
module pwfd_back
  import pwfd_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  edge_class_t item,
  output logic        item_pop,
  input  logic        res_full,
  output logic        res_push,
  output result_t     res
);

  localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);

  phase_t              phase, phase_next;
  logic [BITPOS_W-1:0] bit_position, bit_position_next;
  logic [BYTE_W-1:0]   partial_byte, partial_byte_next;
  logic                odd_half, odd_half_next;
  logic [CNT_W-1:0]    bytes_stored, bytes_stored_next;
  logic [EXPECT_W-1:0] expected_bytes, expected_bytes_next;
  logic                advance;

  assign advance  = item_valid && !res_full;
  assign item_pop = advance;
  assign res_push = advance && (res.byte_valid || res.frame_done);

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_position   <= '0;
      partial_byte   <= '0;
      odd_half       <= 1'b0;
      bytes_stored   <= '0;
      expected_bytes <= '0;
    end else begin
      phase          <= phase_next;
      bit_position   <= bit_position_next;
      partial_byte   <= partial_byte_next;
      odd_half       <= odd_half_next;
      bytes_stored   <= bytes_stored_next;
      expected_bytes <= expected_bytes_next;
    end
  end

  // Step the decoder by one edge
  always_comb begin
    logic take;
    logic [BYTE_W-1:0] byte_val;
    phase_next          = phase;
    bit_position_next   = bit_position;
    partial_byte_next   = partial_byte;
    odd_half_next       = odd_half;
    bytes_stored_next   = bytes_stored;
    expected_bytes_next = expected_bytes;
    res                 = '0;
    take                = 1'b0;
    byte_val            = '0;

    if (advance) begin
      // Timeout or first high edge
      if (phase_next != PH_IDLE && item.over_gap) begin
        if (phase_next == PH_DATA) begin
          res.frame_done   = 1'b1;
          res.timed_out    = 1'b1;
          res.frame_length = LENGTH_W'(bytes_stored_next);
        end
        phase_next = PH_IDLE;
      end else if (item.level && phase_next == PH_IDLE) begin
        phase_next = PH_START1;
      end

      // Long high pulse ended by a falling edge restarts the preamble
      if (!item.level && item.over_first) begin
        phase_next = PH_START2;
      end

      if (item.level && phase_next == PH_START2) begin
        phase_next = item.over_second ? PH_START3 : PH_IDLE;
      end else if (phase_next == PH_START3) begin
        phase_next = item.over_third ? PH_START4 : PH_IDLE;
      end else if (phase_next == PH_START4) begin
        phase_next = item.over_fourth ? PH_DUMMY : PH_IDLE;
      end else if (phase_next == PH_DUMMY) begin
        bit_position_next = '0;
        odd_half_next     = 1'b0;
        partial_byte_next = '0;
        bytes_stored_next = '0;
        phase_next        = PH_DATA;
      end else if (phase_next == PH_DATA) begin
        // A long pulse samples; a short pulse samples only when it follows an unsampled short pulse
        take          = item.long_pulse || odd_half;
        odd_half_next = !take;
        if (take) begin
          byte_val = partial_byte;
          byte_val[bit_position] = partial_byte[bit_position] | item.level;
          if (bit_position == BITPOS_W'(BYTE_W - 1)) begin
            bit_position_next = '0;
            if (bytes_stored == '0) begin
              expected_bytes_next = {1'b0, byte_val} + LENGTH_OFFSET;
            end
            if (bytes_stored < CNT_W'(FRAME_CAPACITY)) begin
              res.byte_valid    = 1'b1;
              res.data_byte     = byte_val;
              res.byte_index    = INDEX_W'(bytes_stored);
              bytes_stored_next = bytes_stored + CNT_W'(1);
            end
            partial_byte_next = '0;
          end else begin
            partial_byte_next = byte_val;
            bit_position_next = bit_position + BITPOS_W'(1);
          end
        end
        // Frame ends by count
        if (expected_bytes_next != '0 &&
            EXPECT_W'(bytes_stored_next) >= expected_bytes_next) begin
          res.frame_done    = 1'b1;
          res.timed_out     = 1'b0;
          res.frame_length  = LENGTH_W'(bytes_stored_next);
          bytes_stored_next = '0;
          phase_next        = PH_IDLE;
        end
      end
    end
  end

endmodule

// File: sv/pwfd_outq.sv
// ----------------------------------------------------------------------------
// pwfd_outq
// Short result queue between the decoder and the receiver.
// ----------------------------------------------------------------------------
module pwfd_outq
  import pwfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res,
  output logic    res_full,
  input  logic    pop,
  output logic    empty,
  output result_t head
);

  result_t           qmem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign res_full = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_pop   = pop && !empty;
  assign head     = qmem[rd_ptr];

  // Store results
  always_ff @(posedge clk) begin
    if (res_push) begin
      qmem[wr_ptr] <= res;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (res_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!res_push && do_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: sv/pulse_width_frame_decoder.sv
// ----------------------------------------------------------------------------
// pulse_width_frame_decoder
// Decodes pulse-width coded radio frames from a stream of line edges.
// ----------------------------------------------------------------------------
// Input: one edge per transfer (line_level, interval), taken when push is
// high and full is low. Results: while empty is low the oldest result is on
// byte_valid, data_byte, byte_index, frame_done, frame_length and timed_out;
// pop takes it. An edge gives zero or one result.
// Thresholds: write cfg_data to register cfg_index with cfg_valid; cfg_ready
// is always high. Write only while no edge is in flight.
// An edge is registered in the edge queue; the decoder then writes its result
// into the result queue, waiting while that queue is full.
// Throughput: one edge per clock while the result queue has room; the decoder
// then steps once per clock, limited by its single phase and byte state.
// Reset restores the default thresholds, returns to idle and empties both
// queues. If the receiver stops popping, the two-entry result queue fills,
// the decoder stops, the two-entry edge queue fills, and full rises.
// ----------------------------------------------------------------------------
module pulse_width_frame_decoder
  import pwfd_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic                 line_level,
  input  logic [TIME_W-1:0]    interval,
  output logic                 empty,
  input  logic                 pop,
  output logic                 byte_valid,
  output logic [BYTE_W-1:0]    data_byte,
  output logic [INDEX_W-1:0]   byte_index,
  output logic                 frame_done,
  output logic [LENGTH_W-1:0]  frame_length,
  output logic                 timed_out
);

  logic        item_valid;
  edge_class_t item;
  logic        item_pop;
  logic        res_full;
  logic        res_push;
  result_t     res;
  result_t     head;

  pwfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .line_level (line_level),
    .interval   (interval),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  pwfd_back #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  pwfd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign byte_valid   = head.byte_valid;
  assign data_byte    = head.data_byte;
  assign byte_index   = head.byte_index;
  assign frame_done   = head.frame_done;
  assign frame_length = head.frame_length;
  assign timed_out    = head.timed_out;

endmodule

// File: sv/pwfd_checker.sv
// ----------------------------------------------------------------------------
// pwfd_checker
// Port-level checks of the pulse-width frame decoder.
// ----------------------------------------------------------------------------
`include "pulse_width_frame_decoder_macros.svh"

module pwfd_checker
  import pwfd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 empty,
  input logic                 pop,
  input logic                 byte_valid,
  input logic [BYTE_W-1:0]    data_byte,
  input logic [INDEX_W-1:0]   byte_index,
  input logic                 frame_done,
  input logic [LENGTH_W-1:0]  frame_length,
  input logic                 timed_out
);

  // Reset empties the result queue
  `PWFD_ASSERT_ALWAYS(a_reset_empty, rst |=> empty, "result pending after reset")

  // Every result carries a byte or a frame end
  `PWFD_ASSERT(a_result_content, !empty |-> (byte_valid || frame_done),
               "result with neither byte nor frame end")

  // Unused fields read zero
  `PWFD_ASSERT(a_unused_zero,
               !empty |-> ((byte_valid || (data_byte == '0 && byte_index == '0)) &&
                           (frame_done || (frame_length == '0 && !timed_out))),
               "unused result field not zero")

  // A waiting result holds until popped
  `PWFD_ASSERT(a_result_hold,
               (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(frame_length)),
               "waiting result changed")

endmodule

bind pulse_width_frame_decoder pwfd_checker u_checker (.*);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the pulse-width frame decoder. Edges go in through the push
// side, decoded bytes and frame ends come out through the pop side. A frame
// tracker follows the decoder state edge by edge and checks every popped
// result, field by field, against the oldest one it predicted. The run covers
// a short directed frame, then random preambles, frames, truncated and
// dropped frames and noise under several threshold settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import pwfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 8;
  localparam int TIME_MAX       = (1 << TIME_W) - 1;
  localparam int ANY_LEVEL      = -1;

  // Ways to close a random frame
  localparam int END_NONE    = 0;
  localparam int END_TIMEOUT = 1;
  localparam int END_DROP    = 2;

  // Follows the decoder edge by edge and holds the results still to be popped
  class frame_tracker;
    logic [TIME_W-1:0]   thr [6];
    phase_t              ph;
    logic [BITPOS_W-1:0] bit_pos;
    logic [BYTE_W-1:0]   shift_byte;
    bit                  half_seen;
    int unsigned         stored;
    int unsigned         target_len;
    result_t             expected_q [$];
    int unsigned         mismatch_count;

    function void restart();
      thr[REG_FIRST_START]  = FIRST_START_RST;
      thr[REG_SECOND_START] = SECOND_START_RST;
      thr[REG_THIRD_START]  = THIRD_START_RST;
      thr[REG_FOURTH_START] = FOURTH_START_RST;
      thr[REG_GAP_TIMEOUT]  = GAP_TIMEOUT_RST;
      thr[REG_LONG_PULSE]   = LONG_PULSE_RST;
      ph             = PH_IDLE;
      bit_pos        = '0;
      shift_byte     = '0;
      half_seen      = 1'b0;
      stored         = 0;
      target_len     = 0;
      mismatch_count = 0;
      expected_q.delete();
    endfunction

    // Advance the decoder state by one edge; queue a result if it makes one
    function void note_edge(logic lvl, logic [TIME_W-1:0] t);
      result_t r;
      bit      take;
      r = '0;

      // Gap timeout leaves any active phase; in data it closes the frame
      if (ph != PH_IDLE && t > thr[REG_GAP_TIMEOUT]) begin
        if (ph == PH_DATA) begin
          r.frame_done   = 1'b1;
          r.timed_out    = 1'b1;
          r.frame_length = LENGTH_W'(stored);
        end
        ph = PH_IDLE;
      end else if (lvl && ph == PH_IDLE) begin
        ph = PH_START1;
      end

      // A low edge after a long pulse restarts the preamble from any phase
      if (!lvl && t > thr[REG_FIRST_START])
        ph = PH_START2;

      if (lvl && ph == PH_START2) begin
        ph = (t > thr[REG_SECOND_START]) ? PH_START3 : PH_IDLE;
      end else if (ph == PH_START3) begin
        ph = (t > thr[REG_THIRD_START]) ? PH_START4 : PH_IDLE;
      end else if (ph == PH_START4) begin
        ph = (t > thr[REG_FOURTH_START]) ? PH_DUMMY : PH_IDLE;
      end else if (ph == PH_DUMMY) begin
        bit_pos    = '0;
        half_seen  = 1'b0;
        shift_byte = '0;
        stored     = 0;
        ph         = PH_DATA;
      end else if (ph == PH_DATA) begin
        // Long pulses always sample; a short one samples only after an unsampled short one
        take = 1'b0;
        if (t > thr[REG_LONG_PULSE]) begin
          take      = 1'b1;
          half_seen = 1'b0;
        end else if (half_seen) begin
          take      = 1'b1;
          half_seen = 1'b0;
        end else begin
          half_seen = 1'b1;
        end
        if (take) begin
          if (lvl)
            shift_byte[bit_pos] = 1'b1;
          if (bit_pos == BITPOS_W'(BYTE_W - 1)) begin
            bit_pos = '0;
            if (stored == 0)
              target_len = int'(shift_byte) + int'(LENGTH_OFFSET);
            if (stored < FRAME_CAPACITY_DEFAULT) begin
              r.byte_valid = 1'b1;
              r.data_byte  = shift_byte;
              r.byte_index = INDEX_W'(stored);
              stored++;
            end
            shift_byte = '0;
          end else begin
            bit_pos++;
          end
        end
        // Close the frame once the announced length is stored
        if (target_len != 0 && stored >= target_len) begin
          r.frame_done   = 1'b1;
          r.timed_out    = 1'b0;
          r.frame_length = LENGTH_W'(stored);
          stored         = 0;
          ph             = PH_IDLE;
        end
      end

      if (r.byte_valid || r.frame_done)
        expected_q.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf("valid=%0b byte=%h index=%0d done=%0b length=%0d timeout=%0b",
                       r.byte_valid, r.data_byte, r.byte_index, r.frame_done,
                       r.frame_length, r.timed_out);
    endfunction

    function void flag(string what, result_t want, result_t got);
      if (mismatch_count < MAX_REPORTS)
        $display("%0t: %s: expected %s, actual %s", $time, what, show(want), show(got));
      mismatch_count++;
    endfunction

    // Compare one popped result with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        flag("result with none pending", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.byte_valid !== want.byte_valid || got.data_byte !== want.data_byte ||
          got.byte_index !== want.byte_index || got.frame_done !== want.frame_done ||
          got.frame_length !== want.frame_length || got.timed_out !== want.timed_out)
        flag("result mismatch", want, got);
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function int unsigned failures();
      return mismatch_count + expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_data;
  logic                 push;
  logic                 full;
  logic                 line_level;
  logic [TIME_W-1:0]    interval;
  logic                 empty;
  logic                 pop;
  logic                 byte_valid;
  logic [BYTE_W-1:0]    data_byte;
  logic [INDEX_W-1:0]   byte_index;
  logic                 frame_done;
  logic [LENGTH_W-1:0]  frame_length;
  logic                 timed_out;

  frame_tracker tracker;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           n_sent;
  int           stuck_cycles;
  int           phase_items [NUM_PHASES] = '{560, 120, 100, 30, 90, 90, 90, 90};

  pulse_width_frame_decoder dut (.*);

  always #5 clk = ~clk;

  // Stall the receiver at random
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      tracker.check_result({byte_valid, data_byte, byte_index, frame_done,
                            frame_length, timed_out});
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic int min2(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int th(input logic [CFG_IDX_W-1:0] idx);
    return int'(tracker.thr[idx]);
  endfunction

  // Random interval in [lo, hi]; anything at all when the range is empty
  function automatic logic [TIME_W-1:0] pick(int lo, int hi);
    if (hi > TIME_MAX)
      hi = TIME_MAX;
    if (lo > hi)
      return TIME_W'($urandom_range(TIME_MAX));
    return TIME_W'($urandom_range(hi, lo));
  endfunction

  // Offer one edge, hold it until the transfer, return at the next falling edge
  task automatic send_edge(input logic lvl, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push       <= 1'b1;
    line_level <= lvl;
    interval   <= t;
    do @(posedge clk); while (full);
    tracker.note_edge(lvl, t);
    n_sent++;
    @(negedge clk);
  endtask

  // Edge with interval in [lo, hi]; a low edge also stays at or under the first start min
  task automatic send_within(input int lvl, input int lo, input int hi);
    logic lv;
    int   lim;
    lv = (lvl == ANY_LEVEL) ? 1'($urandom_range(1)) : 1'(lvl);
    if (lvl == ANY_LEVEL && !lv && lo > min2(hi, th(REG_FIRST_START)))
      lv = 1'b1;
    lim = lv ? hi : min2(hi, th(REG_FIRST_START));
    send_edge(lv, pick(lo, lim));
  endtask

  task automatic send_noise();
    send_edge(1'($urandom_range(1)),
              $urandom_range(1) ? TIME_W'($urandom_range(TIME_MAX))
                                : TIME_W'($urandom_range(40)));
  endtask

  // Start preamble and dummy edge, now and then with one edge replaced by noise
  task automatic send_preamble();
    int broken;
    broken = ($urandom_range(99) < 15) ? $urandom_range(4) : -1;
    for (int i = 0; i < 5; i++) begin
      if (i == broken)
        send_noise();
      else
        case (i)
          0: send_edge(1'b0, pick(th(REG_FIRST_START) + 1, TIME_MAX));
          1: send_within(1, th(REG_SECOND_START) + 1, th(REG_GAP_TIMEOUT));
          2: send_within(ANY_LEVEL, th(REG_THIRD_START) + 1, th(REG_GAP_TIMEOUT));
          3: send_within(ANY_LEVEL, th(REG_FOURTH_START) + 1, th(REG_GAP_TIMEOUT));
          default: send_within(ANY_LEVEL, 0, th(REG_GAP_TIMEOUT));
        endcase
    end
  endtask

  // Encode a byte LSB first as long pulses or short pairs
  task automatic send_byte(input logic [BYTE_W-1:0] value, input bit long_only);
    int  lng;
    int  gap;
    int  cap;
    bit  b;
    lng = th(REG_LONG_PULSE);
    gap = th(REG_GAP_TIMEOUT);
    for (int i = 0; i < BYTE_W; i++) begin
      b   = value[i];
      cap = b ? gap : min2(gap, th(REG_FIRST_START));
      if (lng + 1 <= cap && (long_only || $urandom_range(1))) begin
        send_within(b, lng + 1, gap);
      end else begin
        send_within(ANY_LEVEL, 0, min2(lng, gap));
        send_within(b, 0, min2(lng, gap));
      end
    end
  endtask

  // One random frame; a big one runs past the capacity and ends on a timeout
  task automatic send_frame(input bit big);
    logic [BYTE_W-1:0] len_byte;
    int                target;
    int                nbytes;
    int                end_kind;
    bit                long_only;
    if (big) begin
      case ($urandom_range(2))
        0:       len_byte = BYTE_W'(FRAME_CAPACITY_DEFAULT - 2);
        1:       len_byte = BYTE_W'(FRAME_CAPACITY_DEFAULT - 1);
        default: len_byte = BYTE_W'($urandom_range(255, FRAME_CAPACITY_DEFAULT));
      endcase
      nbytes    = FRAME_CAPACITY_DEFAULT + 2;
      long_only = 1'b1;
      end_kind  = END_TIMEOUT;
    end else begin
      len_byte = ($urandom_range(9) == 0) ? BYTE_W'($urandom_range(255))
                                          : BYTE_W'($urandom_range(4));
      target = int'(len_byte) + int'(LENGTH_OFFSET);
      case ($urandom_range(5))
        0:       nbytes = $urandom_range(target - 1);
        1:       nbytes = target + $urandom_range(2, 1);
        default: nbytes = target;
      endcase
      if (nbytes > 8)
        nbytes = $urandom_range(8, 1);
      long_only = 1'b0;
      end_kind  = $urandom_range(END_DROP);
    end
    send_preamble();
    for (int i = 0; i < nbytes; i++)
      send_byte((i == 0) ? len_byte : BYTE_W'($urandom_range(255)), long_only);
    case (end_kind)
      END_TIMEOUT: send_edge(1'($urandom_range(1)), pick(th(REG_GAP_TIMEOUT) + 1, TIME_MAX));
      END_DROP:    send_edge(1'b0, pick(th(REG_FIRST_START) + 1, TIME_MAX));
      default:     ;
    endcase
  endtask

  // Drop push, wait for every pending result, then let the pipeline empty
  task automatic settle();
    push <= 1'b0;
    while (tracker.outstanding() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= TIME_W'(val);
    do @(posedge clk); while (!cfg_ready);
    tracker.thr[idx] = TIME_W'(val);
    @(negedge clk);
  endtask

  task automatic set_all(input int first, input int second, input int third,
                         input int fourth, input int gap, input int lng);
    write_reg(REG_FIRST_START, first);
    write_reg(REG_SECOND_START, second);
    write_reg(REG_THIRD_START, third);
    write_reg(REG_FOURTH_START, fourth);
    write_reg(REG_GAP_TIMEOUT, gap);
    write_reg(REG_LONG_PULSE, lng);
    cfg_valid <= 1'b0;
  endtask

  // Threshold setting of each random phase: defaults, extremes, then random
  task automatic program_thresholds(input int k);
    case (k)
      0: set_all(80, 80, 20, 20, 200, 20);
      1: set_all(0, 0, 0, 0, TIME_MAX, 0);
      2: set_all(500, TIME_MAX - 1, TIME_MAX - 1, TIME_MAX - 1, TIME_MAX, TIME_MAX);
      3: set_all(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, 0, TIME_MAX);
      default: set_all($urandom_range(900, 30), $urandom_range(250), $urandom_range(250),
                       $urandom_range(250), $urandom_range(TIME_MAX, 260), $urandom_range(250));
    endcase
  endtask

  initial begin
    int stop_at;
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = REG_FIRST_START;
    cfg_data       = '0;
    push           = 1'b0;
    line_level     = 1'b0;
    interval       = '0;
    pop            = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    n_sent         = 0;
    stuck_cycles   = 0;
    tracker        = new;
    tracker.restart();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset thresholds: a two-byte frame whose third and fourth start
    // edges are both high, ended by count; then a failed start
    send_edge(1'b1, 0);
    send_edge(1'b0, TIME_MAX);
    send_edge(1'b1, 100);
    send_edge(1'b1, 30);
    send_edge(1'b1, 30);
    send_edge(1'b0, 5);
    repeat (8) send_edge(1'b0, 50);
    repeat (8) send_edge(1'b1, 200);
    send_edge(1'b1, TIME_MAX);
    send_edge(1'b0, TIME_MAX);
    send_edge(1'b1, 0);
    settle();

    // Random phases, each with its own thresholds and idle mix
    for (int k = 0; k < NUM_PHASES; k++) begin
      program_thresholds(k);
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      stop_at = n_sent + phase_items[k];
      if (k == 0)
        send_frame(1'b1);
      while (n_sent < stop_at) begin
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(4, 1)) send_noise();
        else
          send_frame(1'b0);
      end
      settle();
    end

    if (tracker.failures() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/pwfd_pkg.sv
sv/pwfd_front.sv
sv/pwfd_back.sv
sv/pwfd_outq.sv
sv/pulse_width_frame_decoder.sv
sv/pwfd_checker.sv
dv/tb_top.sv
